/* rtl/mppt_pkg.sv */
// Package for the perturb-and-observe duty tracker: operation codes,
// register indexes, field widths and reset constants.
// No dependencies.
package mppt_pkg;

    // Field widths.
    localparam int DUTY_BITS   = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int PORT_BITS   = 16;
    localparam int POWER_BITS  = 32;
    localparam int CFG_IDX_BITS = 3;

    // Signed width that holds a duty plus or minus a step.
    localparam int WIDE_BITS = DUTY_BITS + 2;

    // Samples are masked to the sample width before use.
    localparam logic [PORT_BITS-1:0] SAMPLE_MASK =
        (SAMPLE_BITS >= PORT_BITS) ? {PORT_BITS{1'b1}}
                                   : PORT_BITS'((32'd1 << SAMPLE_BITS) - 32'd1);

    // Reset values; the duty values are in thousandths of the period.
    localparam logic [DUTY_BITS-1:0] DUTY_RESET      = 10'd100;
    localparam logic [DUTY_BITS-1:0] DUTY_MIN_RESET  = 10'd100;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX_RESET  = 10'd950;
    localparam logic [DUTY_BITS-1:0] DUTY_STEP_RESET = 10'd20;
    localparam logic [DUTY_BITS-1:0] SWEEP_LOW_RESET  = 10'd100;
    localparam logic [DUTY_BITS-1:0] SWEEP_HIGH_RESET = 10'd950;
    localparam logic [DUTY_BITS-1:0] SWEEP_STEP_RESET = 10'd10;
    localparam logic [PORT_BITS-1:0] LIMIT_RESET     = 16'hFFFF;

    // Operation codes carried with each input transaction.
    typedef enum logic [2:0] {
        OP_TRACK      = 3'd0,
        OP_RESET      = 3'd1,
        OP_NUDGE_UP   = 3'd2,
        OP_NUDGE_DOWN = 3'd3,
        OP_SWEEP      = 3'd4,
        OP_LIMIT      = 3'd5
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DUTY_MIN      = 3'd0,
        REG_DUTY_MAX      = 3'd1,
        REG_DUTY_STEP     = 3'd2,
        REG_VOLT_TRIP     = 3'd3,
        REG_CURR_TRIP     = 3'd4,
        REG_SWEEP_LOW     = 3'd5,
        REG_SWEEP_HIGH    = 3'd6,
        REG_SWEEP_STEP    = 3'd7
    } reg_idx_t;

endpackage

/* rtl/mppt_perturb_observe_duty.sv */
// Perturb-and-observe maximum power point tracker producing a PWM duty.
// Throughput: one transaction per cycle unless the result register is stalled;
// the input register feeds one pass of multiply, compare and duty step/clamp
// logic into the result register.
// Reset: asynchronous, active low; all but the data payload registers reset.
// Depends on mppt_pkg.
module mppt_perturb_observe_duty (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input channel.
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0]                       op,
    input  logic [mppt_pkg::PORT_BITS-1:0]   voltage_sample,
    input  logic [mppt_pkg::PORT_BITS-1:0]   current_sample,
    // Result channel.
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mppt_pkg::DUTY_BITS-1:0]   duty_out,
    output logic                             gate_enable,
    output logic [mppt_pkg::POWER_BITS-1:0]  power_out,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mppt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [mppt_pkg::PORT_BITS-1:0]   cfg_data
);
    import mppt_pkg::*;

    // Configuration registers.
    logic [DUTY_BITS-1:0] duty_min_reg, duty_max_reg, duty_step_reg;
    logic [DUTY_BITS-1:0] sweep_low_reg, sweep_high_reg, sweep_step_reg;
    logic [PORT_BITS-1:0] volt_trip_reg, curr_trip_reg;

    // Tracker state.
    logic [DUTY_BITS-1:0]  duty_reg, duty_next;
    logic                  going_up_reg, going_up_next;
    logic [POWER_BITS-1:0] prev_power_reg, prev_power_next;
    logic [POWER_BITS-1:0] rep_power_reg, rep_power_next;
    logic                  driver_reg, driver_next;
    logic                  sweep_desc_reg, sweep_desc_next;

    // Input register stage.
    logic                 in_valid_reg;
    op_t                  op_reg;
    logic [PORT_BITS-1:0] volt_reg, curr_reg;

    // Result register stage.
    logic                  out_valid_reg;
    logic [DUTY_BITS-1:0]  duty_out_reg;
    logic                  driver_out_reg;
    logic [POWER_BITS-1:0] power_out_reg;

    logic advance;
    logic [PORT_BITS-1:0]  volt_m, curr_m;
    logic [POWER_BITS-1:0] product;
    logic signed [WIDE_BITS-1:0] duty_s, step_s, sweep_s, raw_duty, clamped;
    logic signed [WIDE_BITS-1:0] min_s, max_s;
    logic                  do_clamp;

    // Handshake: the input stage moves on whenever the result register is free.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign duty_out    = duty_out_reg;
    assign gate_enable = driver_out_reg;
    assign power_out   = power_out_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_min_reg      <= DUTY_MIN_RESET;
            duty_max_reg      <= DUTY_MAX_RESET;
            duty_step_reg     <= DUTY_STEP_RESET;
            volt_trip_reg     <= LIMIT_RESET;
            curr_trip_reg     <= LIMIT_RESET;
            sweep_low_reg     <= SWEEP_LOW_RESET;
            sweep_high_reg    <= SWEEP_HIGH_RESET;
            sweep_step_reg    <= SWEEP_STEP_RESET;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_DUTY_MIN:      duty_min_reg      <= cfg_data[DUTY_BITS-1:0];
                REG_DUTY_MAX:      duty_max_reg      <= cfg_data[DUTY_BITS-1:0];
                REG_DUTY_STEP:     duty_step_reg     <= cfg_data[DUTY_BITS-1:0];
                REG_VOLT_TRIP:     volt_trip_reg     <= cfg_data;
                REG_CURR_TRIP:     curr_trip_reg     <= cfg_data;
                REG_SWEEP_LOW:     sweep_low_reg     <= cfg_data[DUTY_BITS-1:0];
                REG_SWEEP_HIGH:    sweep_high_reg    <= cfg_data[DUTY_BITS-1:0];
                REG_SWEEP_STEP:    sweep_step_reg    <= cfg_data[DUTY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Input register: captures one transaction at a time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= op_t'(op);
            volt_reg <= voltage_sample;
            curr_reg <= current_sample;
        end
    end

    // Power: the product of two masked samples always fits in 32 bits.
    assign volt_m  = volt_reg & SAMPLE_MASK;
    assign curr_m  = curr_reg & SAMPLE_MASK;
    assign product = POWER_BITS'(volt_m) * POWER_BITS'(curr_m);

    assign duty_s  = WIDE_BITS'(signed'({2'b00, duty_reg}));
    assign step_s  = WIDE_BITS'(signed'({2'b00, duty_step_reg}));
    assign sweep_s = WIDE_BITS'(signed'({2'b00, sweep_step_reg}));
    assign min_s   = WIDE_BITS'(signed'({2'b00, duty_min_reg}));
    assign max_s   = WIDE_BITS'(signed'({2'b00, duty_max_reg}));

    // Next state for the operation in the input register.
    always_comb
    begin
        duty_next       = duty_reg;
        going_up_next   = going_up_reg;
        prev_power_next = prev_power_reg;
        rep_power_next  = rep_power_reg;
        driver_next     = driver_reg;
        sweep_desc_next = sweep_desc_reg;
        raw_duty        = duty_s;
        do_clamp        = 1'b0;

        case (op_reg)
            OP_TRACK:
            begin
                rep_power_next = product;
                if (product != prev_power_reg)
                begin
                    prev_power_next = product;
                    if (product < prev_power_reg)
                    begin
                        going_up_next = !going_up_reg;
                    end
                end
                driver_next = 1'b1;
                raw_duty    = going_up_next ? (duty_s + step_s) : (duty_s - step_s);
                do_clamp    = 1'b1;
            end
            OP_RESET:
            begin
                driver_next    = 1'b0;
                duty_next      = DUTY_RESET;
                rep_power_next = '0;
                going_up_next  = 1'b1;
            end
            OP_NUDGE_UP:
            begin
                raw_duty = duty_s + step_s;
                do_clamp = 1'b1;
            end
            OP_NUDGE_DOWN:
            begin
                raw_duty = duty_s - step_s;
                do_clamp = 1'b1;
            end
            OP_SWEEP:
            begin
                driver_next = 1'b1;
                do_clamp    = 1'b1;
                if (!sweep_desc_reg)
                begin
                    if (duty_reg >= sweep_high_reg)
                        sweep_desc_next = 1'b1;
                    else
                        raw_duty = duty_s + sweep_s;
                end
                else
                begin
                    if (duty_reg <= sweep_low_reg)
                        sweep_desc_next = 1'b0;
                    else
                        raw_duty = duty_s - sweep_s;
                end
            end
            OP_LIMIT:
            begin
                driver_next = !((volt_m >= volt_trip_reg) ||
                                (curr_m >= curr_trip_reg));
            end
            default: ;
        endcase

        // Clamp: the upper bound is tested first.
        if (raw_duty >= max_s)
            clamped = max_s;
        else if (raw_duty <= min_s)
            clamped = min_s;
        else
            clamped = raw_duty;

        if (do_clamp)
        begin
            duty_next = clamped[DUTY_BITS-1:0];
        end
    end

    // State update, taken together with the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg       <= DUTY_RESET;
            going_up_reg   <= 1'b1;
            prev_power_reg <= '0;
            rep_power_reg  <= '0;
            driver_reg     <= 1'b0;
            sweep_desc_reg <= 1'b0;
        end
        else if (advance)
        begin
            duty_reg       <= duty_next;
            going_up_reg   <= going_up_next;
            prev_power_reg <= prev_power_next;
            rep_power_reg  <= rep_power_next;
            driver_reg     <= driver_next;
            sweep_desc_reg <= sweep_desc_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            duty_out_reg   <= duty_next;
            driver_out_reg <= driver_next;
            power_out_reg  <= rep_power_next;
        end
    end

endmodule

/* rtl/mppt_checker.sv */
// Port-level checks for the perturb-and-observe duty tracker, bound to the top.
// Depends on mppt_pkg.
module mppt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic [2:0]                        op,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [mppt_pkg::DUTY_BITS-1:0]    duty_out,
    input logic                              gate_enable,
    input logic [mppt_pkg::POWER_BITS-1:0]   power_out
);
    import mppt_pkg::*;

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty_out) &&
            $stable(gate_enable) && $stable(power_out))
    else $error("result payload changed while stalled");

    // The input side only stalls behind a result that is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no waiting result");

    // A reset transaction returns duty, driver and power to their reset values.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op == OP_RESET) ##1 out_ready |=>
            out_valid && duty_out == DUTY_RESET && !gate_enable && power_out == '0)
    else $error("reset transaction gave a wrong result");

    // A sweep transaction always enables the driver.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op == OP_SWEEP) ##1 out_ready |=>
            out_valid && gate_enable)
    else $error("sweep transaction left the driver off");

endmodule

bind mppt_perturb_observe_duty mppt_checker u_mppt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .duty_out    (duty_out),
    .gate_enable (gate_enable),
    .power_out   (power_out)
);
